/* src/pfa_pkg.sv */
package pfa_pkg;

  // Field widths of the channels and the configuration register
  localparam int OP_W      = 3;
  localparam int PAGE_W    = 14;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 16;
  localparam int RSV_W     = 15;

  // Default sizing
  localparam int NUM_PAGES_DEF  = 16384;
  localparam int COUNT_BITS_DEF = 16;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_INCREF = 3'd1,
    OP_DECREF = 3'd2,
    OP_FREE   = 3'd3,
    OP_INIT   = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_NOMEM = 3'd1,
    ST_REFD  = 3'd2,
    ST_UNDER = 3'd3,
    ST_OVER  = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_RED1,
    S_RED2,
    S_DISP,
    S_POP,
    S_CNT,
    S_MOD,
    S_EMIT
  } state_t;

endpackage

/* src/pfa_ifs.sv */
// Request channel: one operation per beat
interface pfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfa_pkg::OP_W-1:0]    op;
  logic [pfa_pkg::PAGE_W-1:0]  page;

  modport source (output valid, op, page, input ready);
  modport sink   (input valid, op, page, output ready);
endinterface

// Result channel: one result per request
interface pfa_out_if;
  logic                           valid;
  logic                           ready;
  logic [pfa_pkg::STATUS_W-1:0]   status;
  logic [pfa_pkg::PAGE_W-1:0]     granted_page;
  logic [pfa_pkg::CNT_OUT_W-1:0]  ref_count;

  modport source (output valid, status, granted_page, ref_count, input ready);
  modport sink   (input valid, status, granted_page, ref_count, output ready);
endinterface

/* src/page_frame_allocator_refcount_unit.sv */
// Channel   | Dir | Beat contents
// ----------+-----+-------------------------------------------------
// in_ch     | in  | op, page
// out_ch    | out | status, granted_page, ref_count
// cfg_*     | in  | cfg_we, cfg_wdata = reserved_pages (no handshake)
//
// Incref, decref, free and unused codes: page wrap (S_RED1, S_RED2), count
// memory read (S_DISP), then read-modify-write (S_MOD); alloc: free-stack
// read (S_DISP), then count read of the popped page (S_POP), emit in S_CNT;
// init: the sweep that rewrites one count entry per cycle and the free stack below its new top, then S_EMIT.
// After reset the same sweep runs once with in_ch.ready low.
// One item is in work at a time; the output register holds one result and
// the sequencer waits in its final state while that register is still full.
module page_frame_allocator_refcount_unit #(
  parameter int NUM_PAGES  = pfa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = pfa_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  pfa_in_if.sink                    in_ch,
  pfa_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [pfa_pkg::RSV_W-1:0] cfg_wdata
);

  localparam int PW    = pfa_pkg::PAGE_W;
  localparam int AW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int TOP_W = $clog2(NUM_PAGES + 1);
  localparam int CW    = (pfa_pkg::RSV_W > TOP_W) ? pfa_pkg::RSV_W : TOP_W;
  localparam int XW    = ((PW > TOP_W) ? PW : TOP_W) + 1;
  localparam int MW    = PW + TOP_W;
  // floor(2^PW / NUM_PAGES): quotient estimate is low by at most one
  localparam logic [PW-1:0]    RECIP = PW'((1 << PW) / NUM_PAGES);
  localparam logic [TOP_W-1:0] N_TOP = TOP_W'(NUM_PAGES);

  // Memories
  logic [AW-1:0]         stk_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [AW-1:0]         stk_q;
  logic [COUNT_BITS-1:0] cnt_q;

  logic                  stk_we, stk_re, cnt_we, cnt_re;
  logic [AW-1:0]         stk_waddr, stk_raddr, cnt_waddr, cnt_raddr;
  logic [AW-1:0]         stk_wdata;
  logic [COUNT_BITS-1:0] cnt_wdata;

  // Control state
  pfa_pkg::state_t           state_r, state_nxt;
  logic [TOP_W-1:0]          top_r, top_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [TOP_W-1:0]          rsv_eff_r, rsv_eff_nxt;
  logic                      init_pend_r, init_pend_nxt;
  logic                      out_valid_r;
  logic [pfa_pkg::RSV_W-1:0] cfg_r;

  // Item payload
  logic [pfa_pkg::OP_W-1:0]      op_r;
  logic [PW-1:0]                 page_in_r;
  logic [PW-1:0]                 q_r;
  logic [AW-1:0]                 pg_r, pg_nxt;
  logic [pfa_pkg::STATUS_W-1:0]  out_status_r;
  logic [PW-1:0]                 out_page_r;
  logic [pfa_pkg::CNT_OUT_W-1:0] out_cnt_r;

  // Result staging
  logic                         res_valid, emit_go;
  logic [pfa_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0]                res_page;
  logic [COUNT_BITS-1:0]        res_cnt;

  // Datapath helpers
  logic [2*PW-1:0]       prod1;
  logic [MW-1:0]         prod2;
  logic [PW-1:0]         rem0;
  logic [XW-1:0]         rem_x;
  logic [TOP_W:0]        sweep_sum;
  logic [TOP_W-1:0]      rsv_sat;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  push_req;

  // Page wrap, stage 1: quotient estimate
  assign prod1 = (2*PW)'(page_in_r) * (2*PW)'(RECIP);

  // Page wrap, stage 2: remainder with one correction step
  always_comb begin
    prod2 = MW'(q_r) * MW'(NUM_PAGES);
    rem0  = page_in_r - prod2[PW-1:0];
    rem_x = XW'(rem0);
    if (rem_x >= XW'(NUM_PAGES)) begin
      rem_x = rem_x - XW'(NUM_PAGES);
    end
    pg_nxt = AW'(rem_x);
  end

  // Reserved page count saturated at the page count
  assign rsv_sat = (CW'(cfg_r) > CW'(NUM_PAGES)) ? N_TOP : TOP_W'(cfg_r);
  assign sweep_sum = (TOP_W+1)'(idx_r) + (TOP_W+1)'(rsv_eff_r);

  // Free stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  // Reference count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::S_SWEEP;
      top_r       <= N_TOP;
      idx_r       <= '0;
      rsv_eff_r   <= '0;
      init_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      idx_r       <= idx_nxt;
      rsv_eff_r   <= rsv_eff_nxt;
      init_pend_r <= init_pend_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == pfa_pkg::S_IDLE && in_ch.valid) begin
      op_r      <= in_ch.op;
      page_in_r <= in_ch.page;
    end
    if (state_r == pfa_pkg::S_RED1) begin
      q_r <= prod1[2*PW-1:PW];
    end
    if (state_r == pfa_pkg::S_RED2) begin
      pg_r <= pg_nxt;
    end
    if (emit_go) begin
      out_status_r <= res_status;
      out_page_r   <= PW'(res_page);
      out_cnt_r    <= pfa_pkg::CNT_OUT_W'(res_cnt);
    end
  end

  // Sequencer: next state, memory controls and result
  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    idx_nxt       = idx_r;
    rsv_eff_nxt   = rsv_eff_r;
    init_pend_nxt = init_pend_r;
    stk_we        = 1'b0;
    stk_waddr     = idx_r;
    stk_wdata     = AW'(sweep_sum);
    stk_re        = 1'b0;
    stk_raddr     = AW'(top_r - TOP_W'(1));
    cnt_we        = 1'b0;
    cnt_waddr     = idx_r;
    cnt_wdata     = (TOP_W'(idx_r) < rsv_eff_r) ? COUNT_BITS'(1) : '0;
    cnt_re        = 1'b0;
    cnt_raddr     = pg_r;
    res_valid     = 1'b0;
    res_status    = pfa_pkg::ST_OK;
    res_page      = pg_r;
    res_cnt       = cnt_q;
    cnt_new       = cnt_q;
    push_req      = 1'b0;
    emit_go       = 1'b0;

    case (state_r)
      // Rewrite one count entry per cycle, and the stack entry while idx + reserved is below the page count
      pfa_pkg::S_SWEEP: begin
        cnt_we  = 1'b1;
        stk_we  = (sweep_sum < (TOP_W+1)'(NUM_PAGES));
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(NUM_PAGES - 1)) begin
          idx_nxt   = '0;
          top_nxt   = N_TOP - rsv_eff_r;
          state_nxt = init_pend_r ? pfa_pkg::S_EMIT : pfa_pkg::S_IDLE;
        end
      end

      pfa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = pfa_pkg::S_RED1;
        end
      end

      pfa_pkg::S_RED1: state_nxt = pfa_pkg::S_RED2;

      pfa_pkg::S_RED2: state_nxt = pfa_pkg::S_DISP;

      // Issue the first memory read, start the init sweep, or go to S_EMIT for an empty alloc
      pfa_pkg::S_DISP: begin
        case (op_r)
          pfa_pkg::OP_ALLOC: begin
            if (top_r == '0) begin
              state_nxt = pfa_pkg::S_EMIT;
            end else begin
              stk_re    = 1'b1;
              top_nxt   = top_r - TOP_W'(1);
              state_nxt = pfa_pkg::S_POP;
            end
          end
          pfa_pkg::OP_INIT: begin
            rsv_eff_nxt   = rsv_sat;
            init_pend_nxt = 1'b1;
            idx_nxt       = '0;
            state_nxt     = pfa_pkg::S_SWEEP;
          end
          default: begin
            cnt_re    = 1'b1;
            state_nxt = pfa_pkg::S_MOD;
          end
        endcase
      end

      // Count of the popped page
      pfa_pkg::S_POP: begin
        cnt_re    = 1'b1;
        cnt_raddr = stk_q;
        state_nxt = pfa_pkg::S_CNT;
      end

      pfa_pkg::S_CNT: begin
        res_valid = 1'b1;
        res_page  = stk_q;
        emit_go   = !out_valid_r || out_ch.ready;
        if (emit_go) begin
          state_nxt = pfa_pkg::S_IDLE;
        end
      end

      // Read-modify-write of the count, with push on the free stack
      pfa_pkg::S_MOD: begin
        res_valid = 1'b1;
        emit_go   = !out_valid_r || out_ch.ready;
        case (op_r)
          pfa_pkg::OP_INCREF: begin
            if (cnt_q == '1) begin
              res_status = pfa_pkg::ST_OVER;
            end else begin
              cnt_new = cnt_q + COUNT_BITS'(1);
              cnt_we  = emit_go;
            end
          end
          pfa_pkg::OP_DECREF: begin
            if (cnt_q == '0) begin
              res_status = pfa_pkg::ST_UNDER;
            end else begin
              cnt_new  = cnt_q - COUNT_BITS'(1);
              cnt_we   = emit_go;
              push_req = (cnt_new == '0);
            end
          end
          pfa_pkg::OP_FREE: begin
            if (cnt_q != '0) begin
              res_status = pfa_pkg::ST_REFD;
            end else begin
              push_req = 1'b1;
            end
          end
          default: ;
        endcase
        if (push_req) begin
          if (top_r == N_TOP) begin
            res_status = pfa_pkg::ST_FULL;
          end else begin
            stk_we    = emit_go;
            stk_waddr = AW'(top_r);
            stk_wdata = pg_r;
            if (emit_go) begin
              top_nxt = top_r + TOP_W'(1);
            end
          end
        end
        cnt_waddr = pg_r;
        cnt_wdata = cnt_new;
        res_cnt   = cnt_new;
        if (emit_go) begin
          state_nxt = pfa_pkg::S_IDLE;
        end
      end

      // Results that need no memory read: empty alloc, init
      pfa_pkg::S_EMIT: begin
        res_valid = 1'b1;
        if (op_r == pfa_pkg::OP_ALLOC) begin
          res_status = pfa_pkg::ST_NOMEM;
          res_page   = '0;
          res_cnt    = '0;
        end else begin
          res_cnt = (TOP_W'(pg_r) < rsv_eff_r) ? COUNT_BITS'(1) : '0;
        end
        emit_go = !out_valid_r || out_ch.ready;
        if (emit_go) begin
          init_pend_nxt = 1'b0;
          state_nxt     = pfa_pkg::S_IDLE;
        end
      end

      default: state_nxt = pfa_pkg::S_IDLE;
    endcase

    emit_go = emit_go && res_valid;
  end

  // Ports
  assign in_ch.ready         = (state_r == pfa_pkg::S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.granted_page = out_page_r;
  assign out_ch.ref_count    = out_cnt_r;

`ifndef SYNTHESIS
  // Stack pointer never passes the page count
  assert property (@(posedge clk) disable iff (!rst_n) top_r <= N_TOP)
    else $error("free stack pointer above page count");

  // Memories are written only by the sweep or the modify step
  assert property (@(posedge clk) disable iff (!rst_n)
    (stk_we || cnt_we) |-> (state_r == pfa_pkg::S_SWEEP || state_r == pfa_pkg::S_MOD))
    else $error("memory write outside sweep or modify");

  // A successful alloc pops exactly one entry
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfa_pkg::S_DISP && op_r == pfa_pkg::OP_ALLOC && top_r != '0)
      |=> (top_r == $past(top_r) - TOP_W'(1)))
    else $error("alloc did not pop one entry");

  // A result is loaded only when the output register is free or draining
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrote a pending beat");
`endif

endmodule
